// ===== design/chs_pkg.sv =====
`timescale 1ns / 1ps
// chs_pkg: shared types and constants of the chained hash set unit
// no dependencies; imported by every module of the block but chs_ram
package chs_pkg;

  // fibonacci hashing multiplier, 2^32 divided by the golden ratio
  localparam logic [31:0] FIB_MULT = 32'd2654435769;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } chs_op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_POOL_FULL = 2'd3
  } chs_status_e;

  typedef struct packed {
    chs_op_e     op;
    logic [31:0] key;
  } chs_req_t;

endpackage

// ===== design/chs_ram.sv =====
`timescale 1ns / 1ps
// chs_ram: generic single write port, single read port ram, registered read
// no dependencies
module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/chs_front.sv =====
`timescale 1ns / 1ps
// chs_front: accepts items, hashes the key to a bucket and queues them
// depends on chs_pkg
module chs_front
  import chs_pkg::*;
#(
  parameter int BUCKET_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic signed [31:0]     key_i,
  input  logic                   clearing_i,
  output logic                   item_valid_o,
  input  logic                   item_pop_i,
  output chs_req_t               item_o,
  output logic [BUCKET_BITS-1:0] bucket_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  chs_req_t               req_q [QUEUE_DEPTH];
  logic [BUCKET_BITS-1:0] bkt_q [QUEUE_DEPTH];
  logic [PW-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [31:0]            prod;
  logic                   push, pop;

  // low 32 bits of the product; the bucket is its top bits
  assign prod = $unsigned(key_i) * FIB_MULT;

  assign in_stall_o   = clearing_i || (cnt_q == CW'(QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = req_q[rd_ptr_q];
  assign bucket_o     = bkt_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_ptr_q] <= '{op: chs_op_e'(operation_i), key: key_i};
      bkt_q[wr_ptr_q] <= prod[31 -: BUCKET_BITS];
    end
  end

endmodule

// ===== design/chs_back.sv =====
`timescale 1ns / 1ps
// chs_back: executes inserts and chain walks against the bucket and node rams
// depends on chs_pkg and chs_ram
module chs_back
  import chs_pkg::*;
#(
  parameter int BUCKET_BITS = 10,
  parameter int POOL_NODES  = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_pop_o,
  input  chs_req_t               item_i,
  input  logic [BUCKET_BITS-1:0] bucket_i,
  output logic                   clearing_o,
  output logic                   res_valid_o,
  input  logic                   res_stall_i,
  output chs_status_e            status_o
);

  localparam int NW = $clog2(POOL_NODES);
  localparam int UW = $clog2(POOL_NODES + 1);
  localparam int BW = 1 + 2 * NW;
  localparam logic [UW-1:0] POOL_CNT = UW'(POOL_NODES);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_BKT   = 4'b0100,
    S_WALK  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [BUCKET_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic [UW-1:0]          used_q, used_d;
  logic [UW-1:0]          steps_q, steps_d, steps_nx;
  logic [NW-1:0]          cur_q, cur_d, tail_q, tail_d;
  chs_req_t               req_q, req_d;
  logic [BUCKET_BITS-1:0] bkt_q, bkt_d;
  logic                   res_valid_q, res_valid_d;
  chs_status_e            status_q, status_d;

  logic                   bkt_we;
  logic [BUCKET_BITS-1:0] bkt_waddr;
  logic [BW-1:0]          bkt_wdata, bkt_rdata;
  logic                   bkt_ne;
  logic [NW-1:0]          bkt_head, bkt_tail, new_node;
  logic                   key_we, link_we;
  logic [NW-1:0]          link_waddr, node_raddr, link_rdata;
  logic [31:0]            key_rdata;

  assign {bkt_ne, bkt_head, bkt_tail} = bkt_rdata;
  assign new_node = used_q[NW-1:0];
  assign steps_nx = steps_q + UW'(1);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    used_d      = used_q;
    steps_d     = steps_q;
    cur_d       = cur_q;
    tail_d      = tail_q;
    req_d       = req_q;
    bkt_d       = bkt_q;
    res_valid_d = res_valid_q;
    status_d    = status_q;
    item_pop_o  = 1'b0;
    bkt_we      = 1'b0;
    bkt_waddr   = bkt_q;
    bkt_wdata   = '0;
    key_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = bkt_tail;
    node_raddr  = cur_q;

    if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + BUCKET_BITS'(1);
        if (clr_cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // one item in flight; the result slot must be free to take it
        if (item_valid_i && !res_valid_q) begin
          item_pop_o = 1'b1;
          req_d      = item_i;
          bkt_d      = bucket_i;
          state_d    = S_BKT;
        end
      end
      S_BKT: begin
        if (req_q.op == OP_INSERT) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (used_q == POOL_CNT) begin
            status_d = ST_POOL_FULL;
          end else begin
            key_we = 1'b1;
            bkt_we = 1'b1;
            if (bkt_ne) begin
              link_we   = 1'b1;
              bkt_wdata = {1'b1, bkt_head, new_node};
            end else begin
              bkt_wdata = {1'b1, new_node, new_node};
            end
            used_d   = used_q + UW'(1);
            status_d = ST_INSERTED;
          end
        end else if (!bkt_ne) begin
          res_valid_d = 1'b1;
          status_d    = ST_NOT_FOUND;
          state_d     = S_IDLE;
        end else begin
          node_raddr = bkt_head;
          cur_d      = bkt_head;
          tail_d     = bkt_tail;
          steps_d    = '0;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        // node data for cur_q is on the ram outputs; one node per cycle
        priority if (UW'(cur_q) >= POOL_CNT) begin
          res_valid_d = 1'b1;
          status_d    = ST_NOT_FOUND;
          state_d     = S_IDLE;
        end else if (key_rdata == req_q.key) begin
          res_valid_d = 1'b1;
          status_d    = ST_FOUND;
          state_d     = S_IDLE;
        end else if (cur_q == tail_q || steps_nx >= used_q) begin
          res_valid_d = 1'b1;
          status_d    = ST_NOT_FOUND;
          state_d     = S_IDLE;
        end else begin
          node_raddr = link_rdata;
          cur_d      = link_rdata;
          steps_d    = steps_nx;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q  <= steps_d;
    cur_q    <= cur_d;
    tail_q   <= tail_d;
    req_q    <= req_d;
    bkt_q    <= bkt_d;
    status_q <= status_d;
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;

  // bucket word: nonempty, head, tail
  chs_ram #(
    .WIDTH (BW),
    .DEPTH (2 ** BUCKET_BITS)
  ) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .raddr_i (bucket_i),
    .rdata_o (bkt_rdata)
  );

  chs_ram #(
    .WIDTH (32),
    .DEPTH (POOL_NODES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (new_node),
    .wdata_i (req_q.key),
    .raddr_i (node_raddr),
    .rdata_o (key_rdata)
  );

  chs_ram #(
    .WIDTH (NW),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (new_node),
    .raddr_i (node_raddr),
    .rdata_o (link_rdata)
  );

endmodule

// ===== design/chained_hash_set_unit.sv =====
`timescale 1ns / 1ps
// chained hash set: 32-bit keys, fibonacci-hashed buckets, chains in a node pool
// an insert or an empty bucket passes the chs_front queue, the pop with the
// bucket ram read and the result register; a search then walks its chain, one
// node per cycle. one item is in flight at a time: a new item is popped only once
// the result slot has emptied
// reset: a pass over all 2^BUCKET_BITS buckets clears the bucket ram; no input is
// taken until it ends. depends on chs_pkg, chs_front, chs_back, chs_ram
module chained_hash_set_unit
  import chs_pkg::*;
#(
  parameter int BUCKET_BITS = 10,
  parameter int POOL_NODES  = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic signed [31:0] key_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o
);

  chs_req_t               item;
  logic [BUCKET_BITS-1:0] bucket;
  logic                   item_valid, item_pop, clearing;
  chs_status_e            status;

  chs_front #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .clearing_i   (clearing),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item),
    .bucket_o     (bucket)
  );

  chs_back #(
    .BUCKET_BITS (BUCKET_BITS),
    .POOL_NODES  (POOL_NODES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .bucket_i     (bucket),
    .clearing_o   (clearing),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .status_o     (status)
  );

  assign status_o = status;

endmodule

// ===== tb/sv/chs_checker.sv =====
`timescale 1ns / 1ps
// chs_checker: watches both channels of chained_hash_set_unit, predicts each status
// from its own copy of the buckets and node pool, and counts mismatches; uses chs_pkg
module chs_checker
  import chs_pkg::*;
#(
  parameter int BUCKET_BITS = 10,
  parameter int POOL_NODES  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] key_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  status_o,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int BUCKET_COUNT = 1 << BUCKET_BITS;
  localparam int NODE_W       = $clog2(POOL_NODES);

  logic              bucket_used [BUCKET_COUNT];
  logic [NODE_W-1:0] bucket_head [BUCKET_COUNT];
  logic [NODE_W-1:0] bucket_tail [BUCKET_COUNT];
  logic [31:0]       node_key    [POOL_NODES];
  logic [NODE_W-1:0] node_link   [POOL_NODES];
  logic [NODE_W:0]   nodes_used;

  chs_status_e expected_status_q [$];

  function automatic logic [BUCKET_BITS-1:0] bucket_index(logic [31:0] key);
    logic [31:0] prod;
    prod = key * FIB_MULT;
    return prod[31 -: BUCKET_BITS];
  endfunction

  // updates the set on an insert and gives the status the unit should answer
  function automatic chs_status_e apply_request(chs_op_e op, logic [31:0] key);
    logic [BUCKET_BITS-1:0] b;
    logic [NODE_W-1:0]      cur;
    logic [NODE_W-1:0]      fill;
    int                     steps;
    b = bucket_index(key);
    if (op == OP_INSERT) begin
      if (nodes_used >= POOL_NODES) return ST_POOL_FULL;
      fill = nodes_used[NODE_W-1:0];
      node_key[fill]  = key;
      node_link[fill] = fill;
      if (bucket_used[b]) begin
        node_link[bucket_tail[b]] = fill;
      end else begin
        bucket_head[b] = fill;
        bucket_used[b] = 1'b1;
      end
      bucket_tail[b] = fill;
      nodes_used = nodes_used + 1'b1;
      return ST_INSERTED;
    end
    if (!bucket_used[b]) return ST_NOT_FOUND;
    cur = bucket_head[b];
    for (steps = 0; steps < nodes_used; steps++) begin
      if (int'(cur) >= POOL_NODES) return ST_NOT_FOUND;
      if (node_key[cur] == key) return ST_FOUND;
      if (cur == bucket_tail[b]) return ST_NOT_FOUND;
      cur = node_link[cur];
    end
    return ST_NOT_FOUND;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int          fails;
    chs_status_e want;
    if (!rst_ni) begin
      for (int i = 0; i < BUCKET_COUNT; i++) bucket_used[i] = 1'b0;
      nodes_used = '0;
      expected_status_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      fails = fail_count_o;
      if (out_valid_o && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          if (fails < 100)
            $display("%0t: result transfer with no request waiting, actual status %0d",
                     $time, status_o);
          fails++;
        end else begin
          want = expected_status_q.pop_front();
          if (status_o !== want) begin
            if (fails < 100)
              $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                       $time, want, want.name(), status_o);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_status_q.push_back(apply_request(chs_op_e'(operation_i), key_i));
      fail_count_o <= fails;
      pending_o    <= expected_status_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: clock, reset and stimulus for chained_hash_set_unit, plus the final verdict
// depends on chs_pkg, chained_hash_set_unit and chs_checker
module tb;
  import chs_pkg::*;

  localparam int BUCKET_BITS  = 10;
  localparam int POOL_NODES   = 1024;
  localparam int RANDOM_ITEMS = 1530;
  localparam int FILL_ITEMS   = 1200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               operation_i;
  logic signed [31:0] key_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;

  int   fail_count;
  int   pending;
  int   cycle_count;
  int   stall_left;
  logic quiet;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  chained_hash_set_unit #(
    .BUCKET_BITS(BUCKET_BITS),
    .POOL_NODES (POOL_NODES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o)
  );

  chs_checker #(
    .BUCKET_BITS(BUCKET_BITS),
    .POOL_NODES (POOL_NODES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // result side: after each transfer hold stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left  = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        stall_left = quiet ? 0 : $urandom_range(0, 3);
      else if (stall_left > 0)
        stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [BUCKET_BITS-1:0] hash_bucket(logic [31:0] key);
    logic [31:0] prod;
    prod = key * FIB_MULT;
    return prod[31 -: BUCKET_BITS];
  endfunction

  // next key above from that lands in the same bucket as base
  function automatic logic [31:0] next_collider(logic [31:0] base, logic [31:0] from);
    logic [31:0] k;
    k = from + 1;
    while (hash_bucket(k) != hash_bucket(base)) k = k + 1;
    return k;
  endfunction

  task automatic send_item(input chs_op_e op, input logic [31:0] key);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  logic [31:0] recent_keys [64];
  logic [31:0] extreme_keys [4];

  initial begin
    int          recent_count;
    int          roll;
    logic [31:0] key;
    logic [31:0] coll_a;
    logic [31:0] coll_b;
    chs_op_e     op;

    cycle_count  = 0;
    recent_count = 0;
    extreme_keys = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_INSERT;
    key_i       <= '0;
    quiet       <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty bucket, duplicates, extreme keys, a chain walk both ways
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    for (int i = 1; i < 4; i++) send_item(OP_INSERT, extreme_keys[i]);
    for (int i = 1; i < 4; i++) send_item(OP_SEARCH, extreme_keys[i]);
    send_item(OP_SEARCH, 32'h0000_0001);
    coll_a = next_collider(32'd5, 32'd5);
    coll_b = next_collider(32'd5, coll_a);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, coll_a);
    send_item(OP_SEARCH, coll_a);
    send_item(OP_SEARCH, coll_b);
    send_item(OP_SEARCH, 32'd5);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet <= ((i / 200) % 4) == 3;
      if (i % 400 == 399) wait_drained();
      // fill the pool first, then mostly search a full table and hit refusals
      roll = $urandom_range(0, 99);
      op = (roll < ((i < FILL_ITEMS) ? 85 : 40)) ? OP_INSERT : OP_SEARCH;
      roll = $urandom_range(0, 99);
      if (roll < 45 || recent_count == 0) key = $urandom;
      else if (roll < 85) key = recent_keys[$urandom_range(0, recent_count - 1)];
      else if (roll < 92) key = extreme_keys[$urandom_range(0, 3)];
      else key = $urandom_range(0, 255);
      if (op == OP_INSERT) begin
        if (recent_count < 64) begin
          recent_keys[recent_count] = key;
          recent_count++;
        end else begin
          recent_keys[$urandom_range(0, 63)] = key;
        end
      end
      send_item(op, key);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/chs_pkg.sv
design/chs_ram.sv
design/chs_front.sv
design/chs_back.sv
design/chained_hash_set_unit.sv
tb/sv/chs_checker.sv
tb/sv/tb.sv
